@@ design/akr_pkg.sv @@
// ----------------------------------------------------------------------------
// akr_pkg
// Shared types, register map and helpers for the accelerating key repeat.
// ----------------------------------------------------------------------------
package akr_pkg;

  localparam int unsigned CodeW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ActW   = 2;
  localparam int unsigned RegW   = 16;
  localparam int unsigned IdxW   = 3;

  typedef enum logic [IdxW-1:0] {
    REG_PAD_MOVE_DELAY   = 3'd0,
    REG_REM_NAV_DELAY    = 3'd1,
    REG_REM_OTHER_DELAY  = 3'd2,
    REG_INIT_REP_DELAY   = 3'd3,
    REG_REPEAT_MARGIN    = 3'd4,
    REG_REM_NAV_LOW      = 3'd5,
    REG_REM_NAV_HIGH     = 3'd6
  } akr_reg_idx_t;

  typedef enum logic [ActW-1:0] {
    ACT_PAD    = 2'd0,
    ACT_REMOTE = 2'd1,
    ACT_STICK  = 2'd2
  } akr_action_t;

  localparam logic [RegW-1:0] PadMoveDelayRst   = 16'd50;
  localparam logic [RegW-1:0] RemNavDelayRst    = 16'd100;
  localparam logic [RegW-1:0] RemOtherDelayRst  = 16'd200;
  localparam logic [RegW-1:0] InitRepDelayRst   = 16'd300;
  localparam logic [RegW-1:0] RepeatMarginRst   = 16'd50;
  localparam logic [RegW-1:0] RemNavLowRst      = 16'd0;
  localparam logic [RegW-1:0] RemNavHighRst     = 16'd0;
  localparam logic [RegW-1:0] MoveDelayRst      = 16'd50;

  typedef struct packed {
    logic [RegW-1:0] pad_move_delay;
    logic [RegW-1:0] remote_nav_move_delay;
    logic [RegW-1:0] remote_other_move_delay;
    logic [RegW-1:0] initial_repeat_delay;
    logic [RegW-1:0] repeat_margin;
    logic [RegW-1:0] remote_nav_low;
    logic [RegW-1:0] remote_nav_high;
  } akr_cfg_t;

  // floor(2*d/3) by reciprocal multiply: 2d < 2^17, M = ceil(2^18/3)
  function automatic logic [RegW-1:0] shrink_delay(input logic [RegW-1:0] d);
    logic [RegW:0]     x;
    logic [2*RegW+2:0] prod;
    x    = {d, 1'b0};
    prod = {{(RegW+2){1'b0}}, x} * {{(RegW+1){1'b0}}, 18'd87382};
    return prod[18 +: RegW];
  endfunction

endpackage

@@ design/accelerating_key_repeat.sv @@
// ----------------------------------------------------------------------------
// accelerating_key_repeat
// Typematic key repeat filter with accelerating repeat rate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one word per poll carrying the source
//   (in_action), the code (in_dir_code) and the tick count (in_now_ticks).
//   Output channel (out_valid/out_stall): one word per poll, out_code, the
//   passed code or 0 when suppressed, in poll order.
//   Config channel (cfg_valid/cfg_ready): register index and 16-bit data;
//   always ready, write only while no poll is in flight.
//   Latency: a poll's result is registered and shows in the cycle after the
//   poll is accepted. Throughput: one poll per cycle while the output is not
//   stalled, set by the single decision stage updating the hold state.
//   Stall: a full result register holds while out_stall is high; in_stall is
//   raised only while that register is full and stalled.
//   Reset: rst_n (synchronous, active low) restores register defaults,
//   clears the hold state and sets the move delay to 50 ticks.
// ----------------------------------------------------------------------------
module accelerating_key_repeat (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [akr_pkg::ActW-1:0]    in_action,
  input  logic [akr_pkg::CodeW-1:0]   in_dir_code,
  input  logic [akr_pkg::TimeW-1:0]   in_now_ticks,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [akr_pkg::CodeW-1:0]   out_code,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [akr_pkg::IdxW-1:0]    cfg_index,
  input  logic [akr_pkg::RegW-1:0]    cfg_data
);
  import akr_pkg::*;

  akr_cfg_t cfg;

  akr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  logic [CodeW-1:0] held_code_r,   held_code_nxt;
  logic [TimeW-1:0] last_seen_r,   last_seen_nxt;
  logic             repeating_r,   repeating_nxt;
  logic [RegW-1:0]  rep_delay_r,   rep_delay_nxt;
  logic [TimeW-1:0] last_rep_r,    last_rep_nxt;
  logic [RegW-1:0]  move_delay_r,  move_delay_nxt;
  logic             out_valid_r,   out_valid_nxt;
  logic [CodeW-1:0] out_code_r,    out_code_nxt;

  logic             in_acc;
  logic             is_nav;
  logic [TimeW-1:0] move_limit;
  logic [TimeW-1:0] rep_limit;
  logic [CodeW-1:0] result;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;

  assign is_nav     = (in_dir_code >= cfg.remote_nav_low) &&
                      (in_dir_code <= cfg.remote_nav_high);
  assign move_limit = last_seen_r + {{(TimeW-RegW){1'b0}}, move_delay_nxt};
  assign rep_limit  = last_rep_r + {{(TimeW-RegW){1'b0}}, rep_delay_r}
                      + {{(TimeW-RegW){1'b0}}, cfg.repeat_margin};

  always_comb begin
    case (in_action)
      ACT_PAD:    move_delay_nxt = cfg.pad_move_delay;
      ACT_REMOTE: move_delay_nxt = is_nav ? cfg.remote_nav_move_delay
                                          : cfg.remote_other_move_delay;
      default:    move_delay_nxt = move_delay_r;
    endcase
  end

  always_comb begin
    held_code_nxt  = held_code_r;
    last_seen_nxt  = last_seen_r;
    repeating_nxt  = repeating_r;
    rep_delay_nxt  = rep_delay_r;
    last_rep_nxt   = last_rep_r;
    result         = '0;

    if (in_dir_code != '0) begin
      last_seen_nxt = in_now_ticks;
      if ((in_now_ticks > move_limit) || (in_dir_code != held_code_r)) begin
        result        = in_dir_code;
        held_code_nxt = in_dir_code;
        repeating_nxt = 1'b0;
      end else if (repeating_r) begin
        if (in_now_ticks > rep_limit) begin
          rep_delay_nxt = shrink_delay(rep_delay_r);
          last_rep_nxt  = in_now_ticks;
          result        = in_dir_code;
        end
      end else begin
        repeating_nxt = 1'b1;
        rep_delay_nxt = cfg.initial_repeat_delay;
        last_rep_nxt  = in_now_ticks;
      end
    end

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = result;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
      out_code_nxt  = out_code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_code_r  <= '0;
      last_seen_r  <= '0;
      repeating_r  <= 1'b0;
      rep_delay_r  <= '0;
      last_rep_r   <= '0;
      move_delay_r <= MoveDelayRst;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        held_code_r  <= held_code_nxt;
        last_seen_r  <= last_seen_nxt;
        repeating_r  <= repeating_nxt;
        rep_delay_r  <= rep_delay_nxt;
        last_rep_r   <= last_rep_nxt;
        move_delay_r <= move_delay_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
  end

  a_acc_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted poll produced no result word");

  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_dir_code == '0) |=> out_code_r == '0)
    else $error("zero code was not suppressed");

  a_pass_same_code: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_code_r == '0 || out_code_r == $past(in_dir_code)))
    else $error("result word is neither zero nor the polled code");

  a_repeat_held: assert property (@(posedge clk) disable iff (!rst_n)
    repeating_r |-> held_code_r != '0)
    else $error("repeat mode with no held code");

endmodule

@@ design/akr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// akr_cfg_regs
// Configuration register file; always ready, indexes beyond the map ignored.
// ----------------------------------------------------------------------------
module akr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [akr_pkg::IdxW-1:0]    cfg_index,
  input  logic [akr_pkg::RegW-1:0]    cfg_data,
  output akr_pkg::akr_cfg_t           cfg_o
);
  import akr_pkg::*;

  akr_cfg_t cfg_r;
  akr_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PAD_MOVE_DELAY:  cfg_nxt.pad_move_delay          = cfg_data;
        REG_REM_NAV_DELAY:   cfg_nxt.remote_nav_move_delay   = cfg_data;
        REG_REM_OTHER_DELAY: cfg_nxt.remote_other_move_delay = cfg_data;
        REG_INIT_REP_DELAY:  cfg_nxt.initial_repeat_delay    = cfg_data;
        REG_REPEAT_MARGIN:   cfg_nxt.repeat_margin           = cfg_data;
        REG_REM_NAV_LOW:     cfg_nxt.remote_nav_low          = cfg_data;
        REG_REM_NAV_HIGH:    cfg_nxt.remote_nav_high         = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pad_move_delay          <= PadMoveDelayRst;
      cfg_r.remote_nav_move_delay   <= RemNavDelayRst;
      cfg_r.remote_other_move_delay <= RemOtherDelayRst;
      cfg_r.initial_repeat_delay    <= InitRepDelayRst;
      cfg_r.repeat_margin           <= RepeatMarginRst;
      cfg_r.remote_nav_low          <= RemNavLowRst;
      cfg_r.remote_nav_high         <= RemNavHighRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
